[design/cbs_pkg.sv]
// cbs_pkg: shared constants and register map for the column blank segmenter
// used by the top level and the testbench; no dependencies
package cbs_pkg;

  // segment table size of the original scheme; the limit in force is one less
  localparam int MAX_CELLS = 128;

  // register reset values
  localparam logic [7:0]  WHITE_THRESHOLD_RESET = 8'd253;
  localparam logic [15:0] REGION_X0_RESET       = 16'd0;
  localparam logic [6:0]  MAX_SEGMENTS_RESET    = 7'd127;

  // largest segment count that the limit may reach
  localparam int       SEG_CAP_INT = (MAX_CELLS - 1 < 127) ? MAX_CELLS - 1 : 127;
  localparam logic [6:0] SEG_CAP   = 7'(SEG_CAP_INT);

  // register map: index into the word-aligned address space
  localparam int ADDR_W = 4;
  typedef enum logic [1:0] {
    REG_WHITE_THRESHOLD = 2'd0,
    REG_REGION_X0       = 2'd1,
    REG_MAX_SEGMENTS    = 2'd2
  } reg_index_t;

endpackage

[design/cbs_if.sv]
// cbs_pix_if and cbs_seg_if: valid/ready channels for pixel words and result words
// depends on nothing; instantiated by whoever connects the top level
interface cbs_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       column_end;
  logic       region_end;

  modport source (output valid, red, green, blue, column_end, region_end, input ready);
  modport sink   (input valid, red, green, blue, column_end, region_end, output ready);
endinterface

interface cbs_seg_if;
  logic        valid;
  logic        ready;
  logic        segment_valid;
  logic [15:0] seg_start;
  logic [15:0] seg_width;
  logic        final_res;
  logic [6:0]  seg_count;

  modport source (output valid, segment_valid, seg_start, seg_width, final_res, seg_count,
                  input ready);
  modport sink   (input valid, segment_valid, seg_start, seg_width, final_res, seg_count,
                  output ready);
endinterface

[design/column_blank_segmenter_top.sv]
// column_blank_segmenter_top: vertical projection segmentation of a pixel stream
// throughput: one pixel word per cycle, save when the stall below holds the input
// the scan state update is one short compare/add step
// an input register and an output register part the two channels; while a result waits,
//   a held pixel word that makes a result stops the input, other pixel words still pass
// reset (rst, synchronous): registers to their reset values, scan state cleared, both stages empty
module column_blank_segmenter_top
  import cbs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  cbs_pix_if.sink             pix,
  cbs_seg_if.source           seg,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // configuration registers
  logic [7:0]  white_threshold;
  logic [15:0] region_x0;
  logic [6:0]  max_segments;

  // scan state
  logic        prev_blank;
  logic        column_blank;
  logic [15:0] column_pos;
  logic [15:0] open_start;
  logic [6:0]  found_count;
  logic        stopped;

  // input register
  logic        in_valid;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic        in_col_end;
  logic        in_reg_end;

  // output register
  logic        out_valid;
  logic        out_seg_valid;
  logic [15:0] out_start;
  logic [15:0] out_width;
  logic        out_final;
  logic [6:0]  out_count;

  // step logic
  logic        white;
  logic        end_col;
  logic [6:0]  seg_limit;
  logic [15:0] x_cur;
  logic [15:0] x_after;
  logic        closed;
  logic [15:0] c_start;
  logic [15:0] c_width;
  logic        emit;
  logic        advance;

  logic        prev_blank_next;
  logic        column_blank_next;
  logic [15:0] column_pos_next;
  logic [15:0] open_start_next;
  logic [6:0]  found_count_next;
  logic        stopped_next;

  reg_index_t  reg_sel;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // register read
  always_comb begin
    case (reg_sel)
      REG_WHITE_THRESHOLD: prdata = {24'd0, white_threshold};
      REG_REGION_X0:       prdata = {16'd0, region_x0};
      REG_MAX_SEGMENTS:    prdata = {25'd0, max_segments};
      default:             prdata = 32'd0;
    endcase
  end

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      white_threshold <= WHITE_THRESHOLD_RESET;
      region_x0       <= REGION_X0_RESET;
      max_segments    <= MAX_SEGMENTS_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_WHITE_THRESHOLD: white_threshold <= pwdata[7:0];
        REG_REGION_X0:       region_x0       <= pwdata[15:0];
        REG_MAX_SEGMENTS:    max_segments    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // per-pixel scan step on the held word
  assign white = (in_red >= white_threshold) && (in_green >= white_threshold) &&
                 (in_blue >= white_threshold);
  assign end_col   = in_col_end || in_reg_end;
  assign seg_limit = (max_segments < SEG_CAP) ? max_segments : SEG_CAP;
  assign x_cur     = region_x0 + column_pos;
  assign x_after   = region_x0 + column_pos + 16'd1;

  always_comb begin
    logic cb;
    cb                = column_blank && white;
    prev_blank_next   = prev_blank;
    column_blank_next = cb;
    column_pos_next   = column_pos;
    open_start_next   = open_start;
    found_count_next  = found_count;
    stopped_next      = stopped;
    closed            = 1'b0;
    c_start           = 16'd0;
    c_width           = 16'd0;

    // column close: open or close a segment, or stop at the segment limit
    if (end_col) begin
      if (!stopped) begin
        if (!cb && prev_blank) begin
          if (found_count >= seg_limit) begin
            stopped_next = 1'b1;
          end else begin
            open_start_next = x_cur;
            prev_blank_next = 1'b0;
          end
        end else if (cb && !prev_blank) begin
          closed           = 1'b1;
          c_start          = open_start;
          c_width          = x_cur - open_start;
          found_count_next = found_count + 7'd1;
          prev_blank_next  = 1'b1;
        end
      end
      column_pos_next   = column_pos + 16'd1;
      column_blank_next = 1'b1;
    end

    // region end closes a segment still open
    if (in_reg_end && !stopped_next && !prev_blank_next) begin
      closed           = 1'b1;
      c_start          = open_start_next;
      c_width          = x_after - open_start_next;
      found_count_next = found_count_next + 7'd1;
      prev_blank_next  = 1'b1;
    end
  end

  assign emit     = closed || in_reg_end;
  assign advance  = in_valid && (!emit || !out_valid || seg.ready);
  assign pix.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pix.ready) begin
      in_valid <= pix.valid;
    end
    if (pix.ready && pix.valid) begin
      in_red     <= pix.red;
      in_green   <= pix.green;
      in_blue    <= pix.blue;
      in_col_end <= pix.column_end;
      in_reg_end <= pix.region_end;
    end
  end

  // scan state update, cleared at region end
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_blank   <= 1'b1;
      column_blank <= 1'b1;
      column_pos   <= 16'd0;
      open_start   <= 16'd0;
      found_count  <= 7'd0;
      stopped      <= 1'b0;
    end else if (advance) begin
      if (in_reg_end) begin
        prev_blank   <= 1'b1;
        column_blank <= 1'b1;
        column_pos   <= 16'd0;
        open_start   <= 16'd0;
        found_count  <= 7'd0;
        stopped      <= 1'b0;
      end else begin
        prev_blank   <= prev_blank_next;
        column_blank <= column_blank_next;
        column_pos   <= column_pos_next;
        open_start   <= open_start_next;
        found_count  <= found_count_next;
        stopped      <= stopped_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (seg.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && emit) begin
      out_seg_valid <= closed;
      out_start     <= c_start;
      out_width     <= c_width;
      out_final     <= in_reg_end;
      out_count     <= found_count_next;
    end
  end

  assign seg.valid         = out_valid;
  assign seg.segment_valid = out_seg_valid;
  assign seg.seg_start     = out_start;
  assign seg.seg_width     = out_width;
  assign seg.final_res     = out_final;
  assign seg.seg_count     = out_count;

`ifndef SYNTH
  // a word handed on with a result always leaves a valid result word
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> out_valid)
    else $error("result word lost after step");

  // a result that is not the region end must carry a closed segment
  a_only_events: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_final |-> out_seg_valid)
    else $error("result word without an event");

  // a stopped scan never has a segment open
  a_stop_closed: assert property (@(posedge clk) disable iff (rst)
    stopped |-> prev_blank)
    else $error("scan stopped with a segment open");

  // region end leaves the scan state cleared
  a_region_clear: assert property (@(posedge clk) disable iff (rst)
    advance && in_reg_end |=> found_count == 7'd0 && !stopped && prev_blank &&
                              column_pos == 16'd0)
    else $error("scan state not cleared after region end");
`endif

endmodule

[dv/column_blank_segmenter_top_tb.sv]
// column_blank_segmenter_top_tb: self-checking testbench for the column blank segmenter
// drives pixel words and the register port, predicts segment reports and checks them in order
// depends on cbs_pkg, the channel interfaces and column_blank_segmenter_top
module column_blank_segmenter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbs_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       column_end;
    logic       region_end;
  } pixel_t;

  typedef struct packed {
    logic        segment_valid;
    logic [15:0] seg_start;
    logic [15:0] seg_width;
    logic        final_res;
    logic [6:0]  seg_count;
  } report_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  cbs_pix_if pix_if ();
  cbs_seg_if seg_if ();

  column_blank_segmenter_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .pix     (pix_if),
    .seg     (seg_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register copies and scan state of the predictor
  logic [7:0]  cfg_white;
  logic [15:0] cfg_region_x0;
  logic [6:0]  cfg_max_segments;
  logic        scan_prev_blank;
  logic        scan_column_blank;
  logic [15:0] scan_column_pos;
  logic [15:0] scan_open_start;
  logic [6:0]  scan_found;
  logic        scan_stopped;

  report_t expected_reports[$];
  report_t checked_report;
  int      fail_count = 0;
  int      stall_cycles = 0;
  bit      idle_en = 1'b1;

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // segment predictor

  function automatic void clear_scan();
    scan_prev_blank   = 1'b1;
    scan_column_blank = 1'b1;
    scan_column_pos   = '0;
    scan_open_start   = '0;
    scan_found        = '0;
    scan_stopped      = 1'b0;
  endfunction

  // close the open segment at column x
  function automatic void close_segment(input logic [15:0] x, output logic [15:0] start,
                                        output logic [15:0] span);
    start           = scan_open_start;
    span            = x - scan_open_start;
    scan_found      = scan_found + 7'd1;
    scan_prev_blank = 1'b1;
  endfunction

  task automatic predict_pixel(input pixel_t p);
    logic        white;
    logic        closed;
    logic [15:0] x;
    logic [15:0] start;
    logic [15:0] span;
    logic [6:0]  seg_limit;
    report_t     r;
    seg_limit = (cfg_max_segments < SEG_CAP) ? cfg_max_segments : SEG_CAP;
    white  = p.red >= cfg_white && p.green >= cfg_white && p.blue >= cfg_white;
    closed = 1'b0;
    start  = '0;
    span   = '0;
    if (!white) scan_column_blank = 1'b0;
    // column boundary: open, close or stop
    if (p.column_end || p.region_end) begin
      x = cfg_region_x0 + scan_column_pos;
      if (!scan_stopped) begin
        if (!scan_column_blank && scan_prev_blank) begin
          if (scan_found >= seg_limit) begin
            scan_stopped = 1'b1;
          end else begin
            scan_open_start = x;
            scan_prev_blank = 1'b0;
          end
        end else if (scan_column_blank && !scan_prev_blank) begin
          closed = 1'b1;
          close_segment(x, start, span);
        end
      end
      scan_column_pos   = scan_column_pos + 16'd1;
      scan_column_blank = 1'b1;
    end
    // region end closes a segment still open
    if (p.region_end && !scan_stopped && !scan_prev_blank) begin
      closed = 1'b1;
      close_segment(cfg_region_x0 + scan_column_pos, start, span);
    end
    if (closed || p.region_end) begin
      r = '{closed, start, span, p.region_end, scan_found};
      expected_reports.push_back(r);
    end
    if (p.region_end) clear_scan();
  endtask

  // ---------------------------------------------------------------------------
  // drivers

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // one pixel word, with random idle cycles ahead of it while idle_en is set
  task automatic send_pixel(input pixel_t p);
    while (idle_en && $urandom_range(99, 0) < 33) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid      <= 1'b1;
    pix_if.red        <= p.red;
    pix_if.green      <= p.green;
    pix_if.blue       <= p.blue;
    pix_if.column_end <= p.column_end;
    pix_if.region_end <= p.region_end;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    predict_pixel(p);
  endtask

  // stop sending and let every pixel in flight drain
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WHITE_THRESHOLD: cfg_white = value[7:0];
      REG_REGION_X0:       cfg_region_x0 = value[15:0];
      REG_MAX_SEGMENTS:    cfg_max_segments = value[6:0];
      default: ;
    endcase
  endtask

  task automatic check_reg(input reg_index_t idx);
    logic [31:0] got;
    logic [31:0] want;
    logic [31:0] mask;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(4 * int'(idx));
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WHITE_THRESHOLD: begin
        want = 32'(cfg_white);
        mask = 32'hff;
      end
      REG_REGION_X0: begin
        want = 32'(cfg_region_x0);
        mask = 32'hffff;
      end
      default: begin
        want = 32'(cfg_max_segments);
        mask = 32'h7f;
      end
    endcase
    if ((got & mask) !== want)
      note_failure($sformatf("register %s read %0h, expected %0h", idx.name(), got, want));
  endtask

  function automatic pixel_t px(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                                input logic ce, input logic re);
    return '{r, g, b, ce, re};
  endfunction

  // white pixel, or (threshold above zero) one with at least one channel under the threshold
  function automatic pixel_t make_pixel(input bit blank, input bit col_end, input bit reg_end);
    pixel_t p;
    if (blank) begin
      p.red   = $urandom_range(255, cfg_white);
      p.green = $urandom_range(255, cfg_white);
      p.blue  = $urandom_range(255, cfg_white);
    end else begin
      p.red   = $urandom_range(255, 0);
      p.green = $urandom_range(255, 0);
      p.blue  = $urandom_range(255, 0);
      if (cfg_white != 8'd0) begin
        case ($urandom_range(2, 0))
          0:       p.red   = $urandom_range(cfg_white - 8'd1, 0);
          1:       p.green = $urandom_range(cfg_white - 8'd1, 0);
          default: p.blue  = $urandom_range(cfg_white - 8'd1, 0);
        endcase
      end
    end
    p.column_end = col_end;
    p.region_end = reg_end;
    return p;
  endfunction

  // result side back-pressure
  always @(posedge clk) seg_if.ready <= !idle_en || ($urandom_range(99, 0) >= 33);

  // ---------------------------------------------------------------------------
  // result checking, in order

  always @(posedge clk) begin
    if (!rst && seg_if.valid && seg_if.ready) begin
      if (expected_reports.size() == 0) begin
        note_failure($sformatf("unexpected result word: seg %0b start %0d width %0d final %0b count %0d",
                     seg_if.segment_valid, seg_if.seg_start, seg_if.seg_width,
                     seg_if.final_res, seg_if.seg_count));
      end else begin
        checked_report = expected_reports.pop_front();
        if (seg_if.segment_valid !== checked_report.segment_valid ||
            seg_if.seg_start !== checked_report.seg_start ||
            seg_if.seg_width !== checked_report.seg_width ||
            seg_if.final_res !== checked_report.final_res ||
            seg_if.seg_count !== checked_report.seg_count)
          note_failure($sformatf({"result mismatch: seg %0b/%0b start %0d/%0d width %0d/%0d",
                                  " final %0b/%0b count %0d/%0d (got/expected)"},
                       seg_if.segment_valid, checked_report.segment_valid,
                       seg_if.seg_start, checked_report.seg_start,
                       seg_if.seg_width, checked_report.seg_width,
                       seg_if.final_res, checked_report.final_res,
                       seg_if.seg_count, checked_report.seg_count));
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (seg_if.valid && seg_if.ready) || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests

  // reset values, extremes written and read back, then reset values again
  task automatic test_register_access();
    check_reg(REG_WHITE_THRESHOLD);
    check_reg(REG_REGION_X0);
    check_reg(REG_MAX_SEGMENTS);
    write_reg(REG_WHITE_THRESHOLD, 32'hffff_ffff);
    write_reg(REG_REGION_X0, 32'hffff_ffff);
    write_reg(REG_MAX_SEGMENTS, 32'hffff_ff80);
    check_reg(REG_WHITE_THRESHOLD);
    check_reg(REG_REGION_X0);
    check_reg(REG_MAX_SEGMENTS);
    write_reg(REG_WHITE_THRESHOLD, 32'(WHITE_THRESHOLD_RESET));
    write_reg(REG_REGION_X0, 32'(REGION_X0_RESET));
    write_reg(REG_MAX_SEGMENTS, 32'(MAX_SEGMENTS_RESET));
    check_reg(REG_MAX_SEGMENTS);
  endtask

  // threshold edges per channel, segment close, region end inside a column
  task automatic test_directed_segments();
    send_pixel(px(8'd255, 8'd255, 8'd255, 1'b1, 1'b0));
    send_pixel(px(8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    send_pixel(px(8'd255, 8'd255, 8'd255, 1'b1, 1'b0));
    send_pixel(px(8'd253, 8'd253, 8'd253, 1'b1, 1'b0));
    send_pixel(px(8'd252, 8'd255, 8'd255, 1'b1, 1'b0));
    send_pixel(px(8'd255, 8'd252, 8'd255, 1'b1, 1'b0));
    send_pixel(px(8'd255, 8'd255, 8'd252, 1'b0, 1'b0));
    send_pixel(px(8'd255, 8'd255, 8'd255, 1'b0, 1'b1));
    // region of one blank column: count only
    send_pixel(px(8'd255, 8'd255, 8'd255, 1'b1, 1'b1));
    // close and end together on a one-pixel region
    send_pixel(px(8'd0, 8'd255, 8'd255, 1'b0, 1'b1));
    // no event words, then a blank region end
    send_pixel(px(8'd254, 8'd254, 8'd254, 1'b0, 1'b0));
    send_pixel(px(8'd1, 8'd2, 8'd3, 1'b1, 1'b0));
    send_pixel(px(8'd255, 8'd255, 8'd255, 1'b1, 1'b1));
    wait_idle();
  endtask

  // segment limit: zero, one, and the threshold extremes
  task automatic test_segment_limit();
    write_reg(REG_MAX_SEGMENTS, 32'd0);
    send_pixel(px(8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
    send_pixel(px(8'd255, 8'd255, 8'd255, 1'b1, 1'b0));
    send_pixel(px(8'd0, 8'd0, 8'd0, 1'b1, 1'b1));
    wait_idle();
    write_reg(REG_MAX_SEGMENTS, 32'd1);
    send_pixel(px(8'd10, 8'd20, 8'd30, 1'b1, 1'b0));
    send_pixel(px(8'd255, 8'd255, 8'd255, 1'b1, 1'b0));
    send_pixel(px(8'd10, 8'd20, 8'd30, 1'b1, 1'b0));
    send_pixel(px(8'd255, 8'd255, 8'd255, 1'b1, 1'b0));
    send_pixel(px(8'd0, 8'd0, 8'd0, 1'b1, 1'b1));
    wait_idle();
    write_reg(REG_WHITE_THRESHOLD, 32'd0);
    send_pixel(px(8'd0, 8'd0, 8'd0, 1'b1, 1'b1));
    wait_idle();
    write_reg(REG_WHITE_THRESHOLD, 32'd255);
    write_reg(REG_MAX_SEGMENTS, 32'd127);
    send_pixel(px(8'd255, 8'd255, 8'd254, 1'b1, 1'b0));
    send_pixel(px(8'd255, 8'd255, 8'd255, 1'b1, 1'b1));
    wait_idle();
    write_reg(REG_WHITE_THRESHOLD, 32'd253);
  endtask

  // x wrap through region_x0, then a long back-to-back stretch of random columns
  task automatic test_coordinate_wrap();
    write_reg(REG_REGION_X0, 32'd65535);
    send_pixel(make_pixel(1'b0, 1'b1, 1'b0));
    send_pixel(make_pixel(1'b0, 1'b1, 1'b0));
    send_pixel(make_pixel(1'b1, 1'b1, 1'b0));
    send_pixel(make_pixel(1'b0, 1'b1, 1'b1));
    wait_idle();
    write_reg(REG_REGION_X0, 32'd0);
    // long stretch with no idling on either side
    idle_en = 1'b0;
    for (int col = 0; col < 40; col++)
      send_pixel(make_pixel(1'($urandom_range(1, 0)), 1'b1, 1'b0));
    send_pixel(make_pixel(1'b1, 1'b1, 1'b1));
    wait_idle();
    idle_en = 1'b1;
  endtask

  // mostly well-formed columns and regions, some noise words
  task automatic send_random_stream(input int n_items);
    int     sent;
    int     height;
    bit     blank;
    bit     reg_end;
    bit     last;
    pixel_t p;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99, 0) < 85) begin
        height  = $urandom_range(3, 1);
        blank   = $urandom_range(99, 0) < 45;
        reg_end = $urandom_range(5, 0) == 0;
        for (int row = 0; row < height; row++) begin
          last = row == height - 1;
          send_pixel(make_pixel(blank || $urandom_range(1, 0), last, last && reg_end));
        end
        sent += height;
      end else begin
        p = '{8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
              $urandom_range(7, 0) == 0};
        send_pixel(p);
        sent++;
      end
    end
  endtask

  // several register settings, changed between phases, often mid-region
  task automatic test_random_regions();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_REGION_X0, $urandom_range(65535, 0));
        end
        1: begin
          write_reg(REG_WHITE_THRESHOLD, 32'd0);
          write_reg(REG_REGION_X0, 32'd0);
          write_reg(REG_MAX_SEGMENTS, 32'd0);
        end
        2: begin
          write_reg(REG_WHITE_THRESHOLD, 32'd255);
          write_reg(REG_REGION_X0, 32'd65535);
          write_reg(REG_MAX_SEGMENTS, 32'd127);
        end
        3: begin
          write_reg(REG_WHITE_THRESHOLD, $urandom_range(255, 0));
          write_reg(REG_REGION_X0, $urandom_range(65535, 0));
          write_reg(REG_MAX_SEGMENTS, $urandom_range(4, 1));
        end
        default: begin
          write_reg(REG_WHITE_THRESHOLD, $urandom_range(255, 0));
          write_reg(REG_REGION_X0, $urandom_range(65535, 0));
          write_reg(REG_MAX_SEGMENTS, ($urandom_range(3, 0) == 0) ?
                    $urandom_range(127, 0) : $urandom_range(5, 0));
        end
      endcase
      send_random_stream(90);
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence

  initial begin
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    pix_if.valid      <= 1'b0;
    pix_if.red        <= '0;
    pix_if.green      <= '0;
    pix_if.blue       <= '0;
    pix_if.column_end <= 1'b0;
    pix_if.region_end <= 1'b0;
    cfg_white         = WHITE_THRESHOLD_RESET;
    cfg_region_x0     = REGION_X0_RESET;
    cfg_max_segments  = MAX_SEGMENTS_RESET;
    clear_scan();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_access();
    test_directed_segments();
    test_segment_limit();
    test_coordinate_wrap();
    test_random_regions();

    pix_if.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/cbs_pkg.sv
design/cbs_if.sv
design/column_blank_segmenter_top.sv
dv/column_blank_segmenter_top_tb.sv
